### design/lfne_pkg.sv
package lfne_pkg;

  // Character codes that steer the field scan.
  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CHAR_TAB    = 8'h09;
  localparam logic [7:0] CHAR_NL     = 8'h0A;
  localparam logic [7:0] CHAR_LPAREN = 8'h28;
  localparam logic [7:0] CHAR_RPAREN = 8'h29;
  localparam logic [7:0] CHAR_MINUS  = 8'h2D;
  localparam logic [7:0] CHAR_PLUS   = 8'h2B;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;

  // Register map.
  localparam int unsigned CFG_ADDR_W = 3;
  localparam logic [0:0]  REG_FIELD_SELECT = 1'b0;

  // Where the scanner stands within the line.
  typedef enum logic [1:0] {
    MODE_BETWEEN = 2'd0,
    MODE_PLAIN   = 2'd1,
    MODE_BRACKET = 2'd2
  } scan_mode_t;

  // One character request.
  typedef struct packed {
    logic [7:0] char_code;
    logic       line_end;
  } in_item_t;

  // One line result.
  typedef struct packed {
    logic               found;
    logic signed [63:0] value;
  } out_item_t;

  // Line summary handed from the scanner to the result stage.
  typedef struct packed {
    logic        found;
    logic        numeric;
    logic        negative;
    logic [63:0] magnitude;
  } pend_t;

endpackage

### design/lfne_cfg.sv
module lfne_cfg import lfne_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output logic [7:0]            field_select
);

  logic [7:0] field_select_r;
  logic       wr_en;
  logic       hit;

  // The register answers at every address whose top bit is zero.
  assign hit   = (paddr[CFG_ADDR_W-1] == REG_FIELD_SELECT);
  assign wr_en = psel && penable && pwrite && hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_select_r <= '0;
    end else if (wr_en) begin
      field_select_r <= pwdata[7:0];
    end
  end

  // Reads return the register, zero elsewhere.
  assign prdata       = hit ? {24'b0, field_select_r} : 32'b0;
  assign pready       = 1'b1;
  assign field_select = field_select_r;

endmodule

### design/lfne_scan.sv
module lfne_scan import lfne_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       item_vld,
  input  in_item_t   item,
  output logic       item_take,
  input  logic [7:0] field_select,
  output logic       pend_vld,
  output pend_t      pend,
  input  logic       pend_ready
);

  scan_mode_t  mode_r, mode_nxt;
  logic [7:0]  count_r, count_nxt;
  logic        cap_r, cap_nxt;
  logic        matched_r, matched_nxt;
  logic        start_r, start_nxt;
  logic        neg_r, neg_nxt;
  logic        bad_r, bad_nxt;
  logic        dseen_r, dseen_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic        pend_vld_r, pend_vld_nxt;
  pend_t       pend_r, pend_nxt;

  logic        blank;
  logic        content;
  logic        is_digit;
  logic        skip;
  logic [7:0]  c;

  // A character without line end never waits; a line end waits for a free slot.
  assign item_take = item_vld && (!item.line_end || !pend_vld_r || pend_ready);

  assign c        = item.char_code;
  assign blank    = (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_NL);
  assign is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);

  // Next scan state for the character in the input register.
  always_comb begin
    mode_nxt    = mode_r;
    count_nxt   = count_r;
    cap_nxt     = cap_r;
    matched_nxt = matched_r;
    start_nxt   = start_r;
    neg_nxt     = neg_r;
    bad_nxt     = bad_r;
    dseen_nxt   = dseen_r;
    acc_nxt     = acc_r;
    content     = 1'b0;
    skip        = 1'b0;

    unique case (mode_r)
      MODE_PLAIN: begin
        if (blank) begin
          cap_nxt   = 1'b0;
          count_nxt = count_r + 8'd1;
          mode_nxt  = MODE_BETWEEN;
        end else begin
          content = 1'b1;
        end
      end
      MODE_BRACKET: begin
        if (c == CHAR_RPAREN) begin
          cap_nxt   = 1'b0;
          count_nxt = count_r + 8'd1;
          mode_nxt  = MODE_BETWEEN;
        end else begin
          content = 1'b1;
        end
      end
      default: begin
        if (!blank) begin
          if (!matched_r && (count_r == field_select)) begin
            matched_nxt = 1'b1;
            cap_nxt     = 1'b1;
            start_nxt   = 1'b1;
          end
          if (c == CHAR_LPAREN) begin
            mode_nxt = MODE_BRACKET;
          end else begin
            mode_nxt = MODE_PLAIN;
            content  = 1'b1;
          end
        end
      end
    endcase

    // Field content of the selected field: optional sign, then digits.
    if (content && cap_nxt) begin
      if (start_nxt) begin
        start_nxt = 1'b0;
        if (c == CHAR_MINUS) begin
          neg_nxt = 1'b1;
          skip    = 1'b1;
        end else if (c == CHAR_PLUS) begin
          skip = 1'b1;
        end
      end
      if (!skip) begin
        if (is_digit) begin
          acc_nxt   = (acc_r << 3) + (acc_r << 1) + {60'b0, c[3:0]};
          dseen_nxt = 1'b1;
        end else begin
          bad_nxt = 1'b1;
        end
      end
    end
  end

  // Line summary register.
  always_comb begin
    pend_vld_nxt = pend_vld_r;
    pend_nxt     = pend_r;
    if (pend_ready) begin
      pend_vld_nxt = 1'b0;
    end
    if (item_take && item.line_end) begin
      pend_vld_nxt       = 1'b1;
      pend_nxt.found     = matched_nxt;
      pend_nxt.numeric   = matched_nxt && dseen_nxt && !bad_nxt;
      pend_nxt.negative  = neg_nxt;
      pend_nxt.magnitude = acc_nxt;
    end
  end

  // Scan state; a line end puts it back to its start values.
  always_ff @(posedge clk) begin
    if (!rst_n || (item_take && item.line_end)) begin
      mode_r    <= MODE_BETWEEN;
      count_r   <= '0;
      cap_r     <= 1'b0;
      matched_r <= 1'b0;
      start_r   <= 1'b1;
      neg_r     <= 1'b0;
      bad_r     <= 1'b0;
      dseen_r   <= 1'b0;
      acc_r     <= '0;
    end else if (item_take) begin
      mode_r    <= mode_nxt;
      count_r   <= count_nxt;
      cap_r     <= cap_nxt;
      matched_r <= matched_nxt;
      start_r   <= start_nxt;
      neg_r     <= neg_nxt;
      bad_r     <= bad_nxt;
      dseen_r   <= dseen_nxt;
      acc_r     <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_vld_r <= 1'b0;
    end else begin
      pend_vld_r <= pend_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
  end

  assign pend_vld = pend_vld_r;
  assign pend     = pend_r;

endmodule

### design/lfne_fmt.sv
module lfne_fmt import lfne_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      pend_vld,
  input  pend_t     pend,
  output logic      pend_ready,
  output logic      out_valid,
  output out_item_t out_data,
  input  logic      out_ready
);

  logic      out_vld_r, out_vld_nxt;
  out_item_t out_r, out_nxt;
  logic [63:0] signed_mag;

  // Apply the sign; a field that is not a number reads as zero.
  assign signed_mag = pend.negative ? (64'd0 - pend.magnitude) : pend.magnitude;

  assign pend_ready = !out_vld_r || out_ready;

  always_comb begin
    out_vld_nxt = out_vld_r;
    out_nxt     = out_r;
    if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
    if (pend_vld && pend_ready) begin
      out_vld_nxt   = 1'b1;
      out_nxt.found = pend.found;
      out_nxt.value = pend.numeric ? signed_mag : 64'sd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

### design/line_field_number_extractor_core.sv
// Each result passes the input register, the line summary register and the output register.
// Throughput: unless stalled, one character request per cycle; the scan state and the 64-bit
// shift-add accumulator update once per cycle, and the sign is applied in the stage after.
// Reset (rst_n low, synchronous) empties all stages, sets field_select to 0 and puts
// the scanner at the start of a line.
module line_field_number_extractor_core import lfne_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic       in_vld_r;
  in_item_t   in_item_r;
  logic       item_take;
  logic [7:0] field_select;
  logic       pend_vld;
  pend_t      pend;
  logic       pend_ready;

  lfne_cfg u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .field_select (field_select)
  );

  // Input register: refilled whenever its request moves on.
  assign in_ready = !in_vld_r || item_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_item_r <= in_data;
    end
  end

  lfne_scan u_scan (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_vld     (in_vld_r),
    .item         (in_item_r),
    .item_take    (item_take),
    .field_select (field_select),
    .pend_vld     (pend_vld),
    .pend         (pend),
    .pend_ready   (pend_ready)
  );

  lfne_fmt u_fmt (
    .clk        (clk),
    .rst_n      (rst_n),
    .pend_vld   (pend_vld),
    .pend       (pend),
    .pend_ready (pend_ready),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .out_ready  (out_ready)
  );

endmodule
